>>> src/adcs_pkg.sv
// ----------------------------------------------------------------------------
// adcs_pkg : shared types, codes and helpers
// Word format, operation and stop codes, controller/datapath interface
// structs and the decimal arithmetic helpers of the accumulator machine.
// ----------------------------------------------------------------------------
package adcs_pkg;

    // store geometry
    localparam int MEM_WORDS = 100;
    localparam int IDX_W     = $clog2(MEM_WORDS);
    localparam int PC_W      = 7;
    localparam int ADDR_W    = 7;
    localparam int WORD_W    = 11;
    localparam int FUNC_W    = 2;
    localparam int RUN_W     = 3;
    localparam int DIG_W     = 4;

    // stream word widths
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 48;

    typedef logic signed [WORD_W-1:0] t_word;

    // decimal limits
    localparam t_word WORD_MAX = 11'sd999;
    localparam t_word WORD_MIN = -11'sd999;
    localparam t_word HALT_LOW = -11'sd100;

    // item functions
    localparam logic [FUNC_W-1:0] FN_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FN_EXEC  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

    // run state / stop codes
    localparam logic [RUN_W-1:0] RS_RUN      = 3'd0;
    localparam logic [RUN_W-1:0] RS_HALT     = 3'd1;
    localparam logic [RUN_W-1:0] RS_PC_ERR   = 3'd2;
    localparam logic [RUN_W-1:0] RS_OPND_ERR = 3'd3;
    localparam logic [RUN_W-1:0] RS_BAD_OP   = 3'd4;
    localparam logic [RUN_W-1:0] RS_BAD_IO   = 3'd5;

    // hundreds digit of an instruction word
    localparam logic [DIG_W-1:0] OP_HLT = 4'd0;
    localparam logic [DIG_W-1:0] OP_ADD = 4'd1;
    localparam logic [DIG_W-1:0] OP_SUB = 4'd2;
    localparam logic [DIG_W-1:0] OP_STA = 4'd3;
    localparam logic [DIG_W-1:0] OP_LDA = 4'd5;
    localparam logic [DIG_W-1:0] OP_BRA = 4'd6;
    localparam logic [DIG_W-1:0] OP_BRZ = 4'd7;
    localparam logic [DIG_W-1:0] OP_BRP = 4'd8;
    localparam logic [DIG_W-1:0] OP_IO  = 4'd9;

    // I/O operands
    localparam logic [PC_W-1:0] IO_INP = 7'd1;
    localparam logic [PC_W-1:0] IO_OUT = 7'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_OPER,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic issue;   // word accepted, start memory access
        logic decode;  // decode fetched word / capture read data
        logic oper;    // apply operand to accumulator
        logic finish;  // load result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_oper;
        logic out_free;
    } t_sts;

    // clamp to the three-digit range
    function automatic t_word sat999(input t_word v);
        t_word r;
        r = v;
        if (v > WORD_MAX) r = WORD_MAX;
        if (v < WORD_MIN) r = WORD_MIN;
        return r;
    endfunction

    // add or subtract with wrap by 1999
    function automatic t_word wrap_add(input t_word a, input t_word b, input logic sub);
        logic signed [WORD_W:0] s;
        logic signed [WORD_W:0] r;
        s = sub ? ($signed({a[WORD_W-1], a}) - $signed({b[WORD_W-1], b}))
                : ($signed({a[WORD_W-1], a}) + $signed({b[WORD_W-1], b}));
        r = s;
        if (s > 12'sd999)  r = s - 12'sd1999;
        if (s < -12'sd999) r = s + 12'sd1999;
        return r[WORD_W-1:0];
    endfunction

    // hundreds digit of a non-negative word (0 for negatives)
    function automatic logic [DIG_W-1:0] hundreds(input t_word w);
        logic [DIG_W-1:0] d;
        d = '0;
        for (int k = 1; k <= 9; k++) begin
            if (w >= $signed(WORD_W'(k * 100))) d = DIG_W'(k);
        end
        return d;
    endfunction

    // digit times one hundred
    function automatic logic [WORD_W-1:0] times100(input logic [DIG_W-1:0] d);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int k = 1; k <= 9; k++) begin
            if (d == DIG_W'(k)) r = WORD_W'(k * 100);
        end
        return r;
    endfunction

endpackage

>>> src/adcs_ctrl.sv
// ----------------------------------------------------------------------------
// adcs_ctrl : sequencing controller
// Steps one word at a time through memory access, decode, operand use and
// result hand-off.
// ----------------------------------------------------------------------------
module adcs_ctrl
    import adcs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                n_state = i_sts.need_oper ? S_OPER : S_DONE;
            end
            S_OPER: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.issue = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
            end
            S_OPER: begin
                o_cmd.oper = 1'b1;
            end
            S_DONE: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

>>> src/adcs_dpath.sv
// ----------------------------------------------------------------------------
// adcs_dpath : datapath
// Word store with one synchronous port, program counter, accumulator,
// run state, instruction decode and the result register.
// ----------------------------------------------------------------------------
module adcs_dpath
    import adcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [ADDR_W-1:0]     i_addr,
    input  t_word                 i_data,
    output logic                  o_out_valid,
    output logic [M_DATA_W-1:0]   o_out_data,
    input  logic                  i_out_ready
);

    // store and its valid bits (unwritten words read as zero)
    t_word               r_mem [0:MEM_WORDS-1];
    logic [MEM_WORDS-1:0] r_valid;
    t_word               r_rd_word;
    logic                r_rd_ok;

    // architectural state
    logic [PC_W-1:0]  r_pc;
    t_word            r_acc;
    logic [RUN_W-1:0] r_run;
    logic [DIG_W-1:0] r_op;

    // current item
    logic [FUNC_W-1:0] r_func;
    t_word             r_data;
    logic              r_out_flag;
    t_word             r_out_value;
    logic              r_in_used;
    t_word             r_read_data;

    // result register
    logic                r_m_valid;
    logic [M_DATA_W-1:0] r_m_data;

    // memory port controls
    logic             mem_rd;
    logic             mem_wr;
    logic [IDX_W-1:0] mem_idx;
    t_word            mem_wdata;

    // decode
    t_word            rd_val;
    logic [DIG_W-1:0] digit;
    logic [WORD_W-1:0] opnd_full;
    logic [PC_W-1:0]  operand;
    logic             exec_go;
    logic [PC_W-1:0]  dec_pc;
    t_word            dec_acc;
    logic [RUN_W-1:0] dec_run;
    logic             dec_rd;
    logic             dec_wr;
    logic             dec_in;
    logic             dec_out;

    assign rd_val    = r_rd_ok ? r_rd_word : '0;
    assign digit     = hundreds(rd_val);
    assign opnd_full = rd_val - times100(digit);
    assign operand   = opnd_full[PC_W-1:0];
    assign exec_go   = (r_func == FN_EXEC) && (r_run == RS_RUN)
                       && (r_pc < PC_W'(MEM_WORDS));

    // instruction decode of the fetched word
    always_comb begin
        dec_pc  = r_pc + PC_W'(1);
        dec_acc = r_acc;
        dec_run = RS_RUN;
        dec_rd  = 1'b0;
        dec_wr  = 1'b0;
        dec_in  = 1'b0;
        dec_out = 1'b0;
        if (rd_val < 0) begin
            // small negatives truncate to a zero opcode
            dec_run = (rd_val > HALT_LOW) ? RS_HALT : RS_BAD_OP;
        end else if (digit == OP_HLT) begin
            dec_run = RS_HALT;
        end else if (digit != OP_IO && operand >= PC_W'(MEM_WORDS)) begin
            dec_run = RS_OPND_ERR;
        end else begin
            case (digit) inside
                OP_ADD, OP_SUB, OP_LDA: dec_rd = 1'b1;
                OP_STA: dec_wr = 1'b1;
                OP_BRA: dec_pc = operand;
                OP_BRZ: begin
                    if (r_acc == '0) dec_pc = operand;
                end
                OP_BRP: begin
                    if (!r_acc[WORD_W-1]) dec_pc = operand;
                end
                OP_IO: begin
                    if (operand == IO_INP) begin
                        dec_acc = sat999(r_data);
                        dec_in  = 1'b1;
                    end else if (operand == IO_OUT) begin
                        dec_out = 1'b1;
                    end else begin
                        dec_run = RS_BAD_IO;
                    end
                end
                default: dec_run = RS_BAD_OP;
            endcase
        end
    end

    // single memory port: item access on issue, operand access on decode
    always_comb begin
        mem_rd    = 1'b0;
        mem_wr    = 1'b0;
        mem_idx   = i_addr[IDX_W-1:0];
        mem_wdata = sat999(i_data);
        if (i_cmd.issue) begin
            case (i_func)
                FN_WRITE: mem_wr = (i_addr < ADDR_W'(MEM_WORDS));
                FN_READ:  mem_rd = (i_addr < ADDR_W'(MEM_WORDS));
                FN_EXEC: begin
                    mem_rd  = (r_pc < PC_W'(MEM_WORDS)) && (r_run == RS_RUN);
                    mem_idx = r_pc[IDX_W-1:0];
                end
                default: mem_rd = 1'b0;
            endcase
        end else if (i_cmd.decode && exec_go) begin
            mem_rd    = dec_rd;
            mem_wr    = dec_wr;
            mem_idx   = operand[IDX_W-1:0];
            mem_wdata = r_acc;
        end
    end

    // store array
    always_ff @(posedge i_clk) begin
        if (mem_wr) r_mem[mem_idx] <= mem_wdata;
        if (mem_rd) r_rd_word <= r_mem[mem_idx];
        r_rd_ok <= mem_rd && r_valid[mem_idx];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (mem_wr) begin
            r_valid[mem_idx] <= 1'b1;
        end
    end

    // machine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= '0;
            r_acc <= '0;
            r_run <= RS_RUN;
        end else if (i_cmd.decode && r_func == FN_EXEC && r_run == RS_RUN) begin
            if (!exec_go) begin
                r_run <= RS_PC_ERR;
            end else begin
                r_pc  <= dec_pc;
                r_acc <= dec_acc;
                r_run <= dec_run;
            end
        end else if (i_cmd.oper) begin
            case (r_op)
                OP_ADD:  r_acc <= wrap_add(r_acc, rd_val, 1'b0);
                OP_SUB:  r_acc <= wrap_add(r_acc, rd_val, 1'b1);
                default: r_acc <= rd_val;
            endcase
        end
    end

    // per-item registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_func      <= i_func;
            r_data      <= i_data;
            r_out_flag  <= 1'b0;
            r_out_value <= '0;
            r_in_used   <= 1'b0;
            r_read_data <= '0;
        end else if (i_cmd.decode) begin
            r_op <= digit;
            if (r_func == FN_READ) r_read_data <= rd_val;
            if (exec_go) begin
                r_in_used  <= dec_in;
                r_out_flag <= dec_out;
                if (dec_out) r_out_value <= r_acc;
            end
        end
    end

    // result register, freed when the word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_m_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_m_data <= {3'b000, r_acc, r_pc, r_read_data, r_in_used,
                         r_out_value, r_out_flag, r_run};
        end
    end

    assign o_sts.need_oper = exec_go && dec_rd && (dec_run == RS_RUN);
    assign o_sts.out_free  = !r_m_valid || i_out_ready;
    assign o_out_valid     = r_m_valid;
    assign o_out_data      = r_m_data;

endmodule

>>> src/accumulator_decimal_cpu_step.sv
// ----------------------------------------------------------------------------
// accumulator_decimal_cpu_step : decimal accumulator machine, one step a word
// Top level joining the sequencing controller and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word carries a function in s_axis_tuser: write a store word,
//   read a store word, or execute one instruction at the program counter.
//   Every input word yields exactly one output word with the run status,
//   output/input flags, read data, program counter and accumulator.
//   A word is taken in the idle state; writes, reads and most instructions
//   then go through decode and done, add/subtract/load through an operand
//   state as well, as the single store port is used for the fetch, then the operand.
//   One word is in flight at a time; the next is taken once the result has
//   been loaded into the output register, even while that result waits.
//   Reset clears the program counter, accumulator, run status and the
//   store's valid bits, so every store word reads as zero until written.
//   If the receiver stalls, the result is held and the block waits with its
//   next result until the output register frees.
// ----------------------------------------------------------------------------
module accumulator_decimal_cpu_step
    import adcs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,  // address[6:0], data[17:7]
    input  logic [FUNC_W-1:0]   s_axis_tuser,  // func[1:0]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata   // status[2:0], out_valid[3],
                                               // out_value[14:4], input_used[15],
                                               // read_data[26:16], pc_now[33:27],
                                               // acc_now[44:34]
);

    t_cmd cmd;
    t_sts sts;

    adcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    adcs_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_func      (s_axis_tuser),
        .i_addr      (s_axis_tdata[ADDR_W-1:0]),
        .i_data      (s_axis_tdata[ADDR_W+WORD_W-1:ADDR_W]),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .i_out_ready (m_axis_tready)
    );

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench : accumulator_decimal_cpu_step
// Drives store writes, store reads and single instruction steps through the
// input stream, with random gaps and back-pressure, and checks every output
// word against a behavioural copy of the machine. A fixed opening sequence
// covers the extremes and each instruction but HLT and BRA. It is followed
// by random programs that never stop, and then by one random stop
// condition. A stop is sticky until reset, so only one is reachable per run.
// ----------------------------------------------------------------------------
module testbench
    import adcs_pkg::*;
();

    localparam logic [FUNC_W-1:0] FN_IDLE = 2'd3;   // unused function code
    localparam int CODE_WORDS = 50;                 // program area, data above it
    localparam int RANDOM_ITEMS = 1600;
    localparam int SETTLE_CYCLES = 20;
    localparam int QUIET_LIMIT = 5000;

    // output word, lowest field in the lowest bits
    typedef struct packed {
        t_word           acc_now;
        logic [PC_W-1:0] pc_now;
        t_word           read_data;
        logic            input_used;
        t_word           out_value;
        logic            out_valid;
        logic [RUN_W-1:0] status;
    } t_step_result;

    typedef struct {
        logic [FUNC_W-1:0] fn;
        logic [ADDR_W-1:0] addr;
        t_word             data;
        bit                typed;
        t_step_result      want;
    } t_row;

    typedef enum int {
        STOP_HALT_POS,
        STOP_HALT_NEG,
        STOP_PC_RANGE,
        STOP_BAD_OP_POS,
        STOP_BAD_OP_NEG,
        STOP_BAD_IO
    } t_stop_kind;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic [FUNC_W-1:0]   s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;

    // machine image kept by the testbench
    t_word            mem_img [MEM_WORDS];
    logic [PC_W-1:0]  pc_img;
    t_word            acc_img;
    logic [RUN_W-1:0] run_img;

    t_step_result pending_steps [$];
    int           mismatches;
    int           quiet_cycles;
    bit           calm;

    accumulator_decimal_cpu_step dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // clamp to three digits
    function automatic t_word limit_word(input int v);
        if (v > 999) return t_word'(999);
        if (v < -999) return t_word'(-999);
        return t_word'(v);
    endfunction

    // fold one step past +-999 back by 1999
    function automatic t_word wrap_word(input int v);
        if (v > 999) return t_word'(v - 1999);
        if (v < -999) return t_word'(v + 1999);
        return t_word'(v);
    endfunction

    function automatic t_word insn(input logic [DIG_W-1:0] dig, input int opnd);
        return t_word'(int'(dig) * 100 + opnd);
    endfunction

    // one word in, one result out; updates the machine image
    function automatic t_step_result step_machine(input logic [FUNC_W-1:0] fn,
                                                  input logic [ADDR_W-1:0] addr,
                                                  input t_word data);
        t_step_result r;
        int w;
        int dig;
        int opnd;
        r = '0;
        if (fn == FN_WRITE) begin
            if (addr < MEM_WORDS) mem_img[addr] = limit_word(int'(data));
        end else if (fn == FN_READ) begin
            if (addr < MEM_WORDS) r.read_data = mem_img[addr];
        end else if (fn == FN_EXEC && run_img == RS_RUN) begin
            if (pc_img >= MEM_WORDS) begin
                run_img = RS_PC_ERR;
            end else begin
                w = int'(mem_img[pc_img]);
                dig = w / 100;              // truncates toward zero
                opnd = w - dig * 100;
                pc_img = pc_img + 1'b1;
                if (dig == int'(OP_HLT)) begin
                    run_img = RS_HALT;
                end else if (dig != int'(OP_IO) && opnd >= MEM_WORDS) begin
                    run_img = RS_OPND_ERR;
                end else begin
                    case (dig)
                        int'(OP_ADD): acc_img = wrap_word(int'(acc_img) + int'(mem_img[opnd]));
                        int'(OP_SUB): acc_img = wrap_word(int'(acc_img) - int'(mem_img[opnd]));
                        int'(OP_STA): mem_img[opnd] = acc_img;
                        int'(OP_LDA): acc_img = mem_img[opnd];
                        int'(OP_BRA): pc_img = PC_W'(opnd);
                        int'(OP_BRZ): if (acc_img == 0) pc_img = PC_W'(opnd);
                        int'(OP_BRP): if (acc_img >= 0) pc_img = PC_W'(opnd);
                        int'(OP_IO): begin
                            if (opnd == int'(IO_INP)) begin
                                acc_img = limit_word(int'(data));
                                r.input_used = 1'b1;
                            end else if (opnd == int'(IO_OUT)) begin
                                r.out_valid = 1'b1;
                                r.out_value = acc_img;
                            end else begin
                                run_img = RS_BAD_IO;
                            end
                        end
                        default: run_img = RS_BAD_OP;
                    endcase
                end
            end
        end
        r.status = run_img;
        r.pc_now = pc_img;
        r.acc_now = acc_img;
        return r;
    endfunction

    // result of a write or read before any instruction has run
    function automatic t_step_result quiet_res(input t_word rd);
        t_step_result r;
        r = '0;
        r.status = RS_RUN;
        r.read_data = rd;
        return r;
    endfunction

    // mostly in range, with extremes, zero and raw 11-bit patterns
    function automatic t_word pick_value();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0: return $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
            1: return t_word'($urandom);
            2: return '0;
            default: return t_word'(int'($urandom_range(0, 1998)) - 999);
        endcase
    endfunction

    function automatic t_word loop_back();
        return insn(OP_BRA, $urandom_range(0, CODE_WORDS - 2));
    endfunction

    // an instruction that keeps the program counter inside the program area
    function automatic t_word pick_safe_insn();
        int k;
        int any_addr;
        int code_addr;
        int data_addr;
        k = $urandom_range(0, 99);
        any_addr = $urandom_range(0, MEM_WORDS - 1);
        code_addr = $urandom_range(0, CODE_WORDS - 1);
        data_addr = $urandom_range(CODE_WORDS, MEM_WORDS - 1);
        if (k < 14) return insn(OP_ADD, any_addr);
        if (k < 28) return insn(OP_SUB, any_addr);
        if (k < 40) return insn(OP_STA, data_addr);
        if (k < 54) return insn(OP_LDA, any_addr);
        if (k < 62) return insn(OP_BRA, code_addr);
        if (k < 72) return insn(OP_BRZ, code_addr);
        if (k < 82) return insn(OP_BRP, code_addr);
        if (k < 91) return insn(OP_IO, int'(IO_INP));
        return insn(OP_IO, int'(IO_OUT));
    endfunction

    // present one word, wait for it to be taken, then log what it should give
    task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [ADDR_W-1:0] addr,
                             input t_word data, input bit typed, input t_step_result want);
        int gap;
        t_step_result got;
        gap = (!calm && $urandom_range(0, 99) < 25) ? $urandom_range(1, 3) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(S_DATA_W - WORD_W - ADDR_W){1'b0}}, data, addr};
        s_axis_tuser <= fn;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        got = step_machine(fn, addr, data);
        pending_steps.insert(pending_steps.size(), typed ? want : got);
    endtask

    task automatic report_field(input string name, input int want_v, input int seen_v);
        if (want_v != seen_v) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, seen_v);
        end
    endtask

    // receiver back-pressure
    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 14);
    end

    // result checker
    always @(posedge i_clk) begin
        t_step_result seen;
        t_step_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = m_axis_tdata[$bits(t_step_result)-1:0];
            if (pending_steps.size() == 0) begin
                mismatches++;
                $display("%0t: result word %h with nothing expected", $time, seen);
            end else begin
                want = pending_steps.pop_front();
                if ($isunknown(seen)) begin
                    mismatches++;
                    $display("%0t: expected %h, got unknown bits %h", $time, want, seen);
                end else if (seen != want) begin
                    report_field("status", want.status, seen.status);
                    report_field("out_valid", want.out_valid, seen.out_valid);
                    report_field("out_value", want.out_value, seen.out_value);
                    report_field("input_used", want.input_used, seen.input_used);
                    report_field("read_data", want.read_data, seen.read_data);
                    report_field("pc_now", want.pc_now, seen.pc_now);
                    report_field("acc_now", want.acc_now, seen.acc_now);
                end
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    initial begin
        t_row         plan [$];
        t_step_result inp_res;
        t_stop_kind   stop;
        int           i;
        int           k;
        int           a;

        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        mismatches = 0;
        quiet_cycles = 0;
        calm = 1'b0;
        foreach (mem_img[j]) mem_img[j] = '0;
        pc_img = '0;
        acc_img = '0;
        run_img = RS_RUN;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // opening sequence: store extremes, ignored addresses, then a short program
        inp_res = quiet_res('0);
        inp_res.input_used = 1'b1;
        inp_res.pc_now = 7'd1;
        inp_res.acc_now = WORD_MIN;
        plan.insert(plan.size(), t_row'{FN_READ, 7'd0, '0, 1'b1, quiet_res('0)});
        plan.insert(plan.size(), t_row'{FN_WRITE, 7'd99, t_word'(-1024), 1'b1, quiet_res('0)});
        plan.insert(plan.size(), t_row'{FN_READ, 7'd99, '0, 1'b1, quiet_res(WORD_MIN)});
        plan.insert(plan.size(), t_row'{FN_WRITE, 7'd127, 11'sd1023, 1'b1, quiet_res('0)});
        plan.insert(plan.size(), t_row'{FN_READ, 7'd127, '0, 1'b1, quiet_res('0)});
        plan.insert(plan.size(), t_row'{FN_IDLE, 7'd5, 11'sd123, 1'b1, quiet_res('0)});
        plan.insert(plan.size(),
                    t_row'{FN_WRITE, 7'd0, insn(OP_IO, int'(IO_INP)), 1'b1, quiet_res('0)});
        plan.insert(plan.size(), t_row'{FN_WRITE, 7'd1, insn(OP_ADD, 99), 1'b1, quiet_res('0)});
        plan.insert(plan.size(), t_row'{FN_WRITE, 7'd2, insn(OP_STA, 98), 1'b1, quiet_res('0)});
        plan.insert(plan.size(), t_row'{FN_WRITE, 7'd3, insn(OP_SUB, 98), 1'b1, quiet_res('0)});
        plan.insert(plan.size(), t_row'{FN_WRITE, 7'd4, insn(OP_BRZ, 6), 1'b1, quiet_res('0)});
        plan.insert(plan.size(), t_row'{FN_WRITE, 7'd6, insn(OP_LDA, 98), 1'b1, quiet_res('0)});
        plan.insert(plan.size(),
                    t_row'{FN_WRITE, 7'd7, insn(OP_IO, int'(IO_OUT)), 1'b1, quiet_res('0)});
        plan.insert(plan.size(), t_row'{FN_WRITE, 7'd8, insn(OP_BRP, 0), 1'b1, quiet_res('0)});
        // input saturates low, add wraps, store, subtract to zero, branch taken
        plan.insert(plan.size(), t_row'{FN_EXEC, 7'd0, t_word'(-1024), 1'b1, inp_res});
        for (i = 0; i < 7; i++) plan.insert(plan.size(), t_row'{FN_EXEC, 7'd0, '0, 1'b0, '0});
        // input saturates high, then back to zero
        plan.insert(plan.size(), t_row'{FN_EXEC, 7'd0, 11'sd1023, 1'b0, '0});
        plan.insert(plan.size(), t_row'{FN_EXEC, 7'd0, '0, 1'b0, '0});
        plan.insert(plan.size(), t_row'{FN_READ, 7'd98, '0, 1'b0, '0});
        foreach (plan[j]) send_item(plan[j].fn, plan[j].addr, plan[j].data,
                                    plan[j].typed, plan[j].want);

        // fill the program area with instructions that never stop
        for (a = 0; a < CODE_WORDS; a++)
            send_item(FN_WRITE, ADDR_W'(a), (a == CODE_WORDS - 1) ? loop_back()
                                                               : pick_safe_insn(), 1'b0, '0);

        // random steps, with store traffic and program rewrites in between
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            calm = (i >= 300 && i < 600);
            if (i == 800) begin
                // withdraw the last word so it is not taken twice while draining
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                while (pending_steps.size() != 0) @(posedge i_clk);
            end
            k = $urandom_range(0, 99);
            if (k < 58) begin
                send_item(FN_EXEC, ADDR_W'($urandom_range(0, 127)), pick_value(), 1'b0, '0);
            end else if (k < 68) begin
                send_item(FN_WRITE, ADDR_W'($urandom_range(CODE_WORDS, MEM_WORDS - 1)),
                          pick_value(), 1'b0, '0);
            end else if (k < 78) begin
                a = $urandom_range(0, CODE_WORDS - 1);
                send_item(FN_WRITE, ADDR_W'(a), (a == CODE_WORDS - 1) ? loop_back()
                                                                   : pick_safe_insn(), 1'b0, '0);
            end else if (k < 90) begin
                send_item(FN_READ, ADDR_W'($urandom_range(0, 127)), pick_value(), 1'b0, '0);
            end else if (k < 95) begin
                send_item(FN_WRITE, ADDR_W'($urandom_range(MEM_WORDS, 127)),
                          pick_value(), 1'b0, '0);
            end else begin
                send_item(FN_IDLE, ADDR_W'($urandom_range(0, 127)), pick_value(), 1'b0, '0);
            end
        end
        calm = 1'b0;

        // one stop condition, placed at the current program counter
        stop = t_stop_kind'($urandom_range(0, 5));
        case (stop)
            STOP_HALT_POS:
                send_item(FN_WRITE, pc_img, t_word'($urandom_range(0, 99)), 1'b0, '0);
            STOP_HALT_NEG:
                send_item(FN_WRITE, pc_img, t_word'(0 - int'($urandom_range(1, 99))), 1'b0, '0);
            STOP_BAD_OP_POS:
                send_item(FN_WRITE, pc_img, t_word'(400 + int'($urandom_range(0, 99))), 1'b0, '0);
            STOP_BAD_OP_NEG:
                send_item(FN_WRITE, pc_img, t_word'(0 - int'($urandom_range(100, 999))), 1'b0, '0);
            STOP_BAD_IO: begin
                k = $urandom_range(3, 100);
                send_item(FN_WRITE, pc_img, insn(OP_IO, (k == 100) ? 0 : k), 1'b0, '0);
            end
            default: begin
                // jump to the last word, run an input there and fall off the end
                send_item(FN_WRITE, 7'd99, insn(OP_IO, int'(IO_INP)), 1'b0, '0);
                send_item(FN_WRITE, pc_img, insn(OP_BRA, 99), 1'b0, '0);
                send_item(FN_EXEC, 7'd0, pick_value(), 1'b0, '0);
                send_item(FN_EXEC, 7'd0, pick_value(), 1'b0, '0);
            end
        endcase
        send_item(FN_EXEC, 7'd0, pick_value(), 1'b0, '0);

        // stop must hold; store access still works
        for (i = 0; i < 3; i++) send_item(FN_EXEC, 7'd0, pick_value(), 1'b0, '0);
        a = $urandom_range(0, MEM_WORDS - 1);
        send_item(FN_WRITE, ADDR_W'(a), pick_value(), 1'b0, '0);
        send_item(FN_READ, ADDR_W'(a), '0, 1'b0, '0);
        send_item(FN_IDLE, 7'd0, '0, 1'b0, '0);
        send_item(FN_EXEC, 7'd0, pick_value(), 1'b0, '0);

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
